>>> rtl/hcx_pkg.sv
// Shared constants, types and step functions of the helium charge-exchange datapath.
package hcx_pkg;

  localparam int unsigned XS_W = 22;
  localparam logic [XS_W-1:0] XS_MAX = 22'h3FFFFF;
  localparam logic [63:0] LOW_CONST = 64'd129960;
  localparam logic [63:0] LIN_NUM = 64'd78872;
  localparam logic [63:0] ROOT_NUM4 = 64'd157974451600;
  localparam logic [63:0] HIGH_SCALE = 64'd1555400;
  localparam logic [63:0] HIGH_CONST = 64'd86407;
  localparam logic [63:0] LN2_Q28 = 64'd186065279;

  localparam int unsigned ROOT_QW = 44;
  localparam int unsigned LIN_QW = 16;
  localparam int unsigned HIGH_QW = 16;
  localparam int unsigned SQRT_STEPS = ROOT_QW / 2;
  localparam int unsigned LOG_STEPS = 30;

  // exact floor(y / 1000) as (y * LIN_RECIP) >> LIN_RECIP_SH for y below 2^LIN_Y_W
  localparam int unsigned LIN_Y_W = 25;
  localparam logic [25:0] LIN_RECIP = 26'd34359739;
  localparam int unsigned LIN_RECIP_SH = 35;

  typedef struct packed {
    logic [63:0] rem;
    logic        bit_q;
  } div_res_t;

  typedef struct packed {
    logic [ROOT_QW-1:0] v;
    logic [ROOT_QW-1:0] r;
  } sqrt_res_t;

  function automatic div_res_t div_step(input logic [63:0] rem, input logic [63:0] d,
                                        input int unsigned sh);
    div_res_t res;
    res.rem = rem;
    res.bit_q = 1'b0;
    if ((rem >> sh) >= d) begin
      res.rem = rem - (d << sh);
      res.bit_q = 1'b1;
    end
    return res;
  endfunction

  function automatic sqrt_res_t sqrt_step(input logic [ROOT_QW-1:0] v,
                                          input logic [ROOT_QW-1:0] r,
                                          input logic [ROOT_QW-1:0] b);
    sqrt_res_t res;
    res.v = v;
    res.r = r >> 1;
    if (v >= r + b) begin
      res.v = v - (r + b);
      res.r = (r >> 1) + b;
    end
    return res;
  endfunction

endpackage

>>> rtl/helium_charge_exchange_cross_section.sv
// Top level: fully pipelined helium charge-exchange cross-section evaluator.
// One energy is taken on every clock (busy is never raised) and its cross section appears on
// out_cross_section, marked by out_strobe, at the end of the pipeline. The latency is set by the
// low-energy path: a 44-stage restoring divider for the inverse energy followed by a
// 22-stage square root; the log and quotient of the high-energy path run alongside and are
// delayed to match. Results cannot be held off, so each one is valid for a single cycle.
module helium_charge_exchange_cross_section #(
  parameter int unsigned ENERGY_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_energy,
  output logic        out_strobe,
  output logic [21:0] out_cross_section
);

  localparam int unsigned LAT = 68;
  localparam logic [63:0] EMIN64 = ((64'd1 << ENERGY_FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] CUT64 = ((64'd3778 << ENERGY_FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [31:0] EMIN = EMIN64[31:0];
  localparam logic [31:0] CUT = CUT64[31:0];
  localparam logic [63:0] ROOT_NUM = hcx_pkg::ROOT_NUM4 << ENERGY_FRAC_BITS;
  localparam logic [63:0] LIN_RND = 64'd500 << ENERGY_FRAC_BITS;
  localparam logic [35:0] FRAC_OFS = 36'(ENERGY_FRAC_BITS) << 30;
  localparam int unsigned D_SH = 30 - ENERGY_FRAC_BITS;
  localparam int unsigned H_SH = 29 - ENERGY_FRAC_BITS;

  localparam int unsigned S_RQ = hcx_pkg::ROOT_QW;           // 44
  localparam int unsigned S_RT = S_RQ + hcx_pkg::SQRT_STEPS; // 66
  localparam int unsigned S_LQ = 3;
  localparam int unsigned S_HX = 2 + hcx_pkg::LOG_STEPS;     // 32
  localparam int unsigned S_HN = S_HX + 5;                   // 37
  localparam int unsigned S_HQ = S_HN + hcx_pkg::HIGH_QW;    // 53

  logic                vld_r [0:LAT];
  logic [31:0]         e_r   [0:S_HQ];
  logic                sel_r [0:S_RT];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
    end
    e_r[0] <= (in_energy < EMIN) ? EMIN : in_energy;
    sel_r[0] <= ((in_energy < EMIN) ? EMIN : in_energy) < CUT;
  end

  for (genvar s = 1; s <= LAT; s++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  for (genvar s = 1; s <= S_HQ; s++) begin : g_e
    always_ff @(posedge clk) begin
      e_r[s] <= e_r[s-1];
    end
  end

  for (genvar s = 1; s <= S_RT; s++) begin : g_sel
    always_ff @(posedge clk) begin
      sel_r[s] <= sel_r[s-1];
    end
  end

  // Low branch: inverse energy quotient
  logic [63:0]                 rd_rem_r [1:S_RQ];
  logic [hcx_pkg::ROOT_QW-1:0] rd_q_r   [1:S_RQ];

  for (genvar i = 0; i < S_RQ; i++) begin : g_rdiv
    logic [63:0]                 src;
    logic [hcx_pkg::ROOT_QW-1:0] qin;
    hcx_pkg::div_res_t           res;
    if (i == 0) begin : g_first
      assign src = ROOT_NUM;
      assign qin = '0;
    end else begin : g_next
      assign src = rd_rem_r[i];
      assign qin = rd_q_r[i];
    end
    assign res = hcx_pkg::div_step(src, {32'd0, e_r[i]}, S_RQ - 1 - i);
    always_ff @(posedge clk) begin
      rd_rem_r[i+1] <= res.rem;
      rd_q_r[i+1] <= {qin[hcx_pkg::ROOT_QW-2:0], res.bit_q};
    end
  end

  // Low branch: integer square root
  logic [hcx_pkg::ROOT_QW-1:0] sq_v_r [S_RQ+1:S_RT];
  logic [hcx_pkg::ROOT_QW-1:0] sq_r_r [S_RQ+1:S_RT];

  for (genvar j = 0; j < hcx_pkg::SQRT_STEPS; j++) begin : g_sqrt
    logic [hcx_pkg::ROOT_QW-1:0] vin;
    logic [hcx_pkg::ROOT_QW-1:0] rin;
    hcx_pkg::sqrt_res_t          res;
    if (j == 0) begin : g_first
      assign vin = rd_q_r[S_RQ];
      assign rin = '0;
    end else begin : g_next
      assign vin = sq_v_r[S_RQ+j];
      assign rin = sq_r_r[S_RQ+j];
    end
    assign res = hcx_pkg::sqrt_step(vin, rin,
                                    hcx_pkg::ROOT_QW'(1) << (hcx_pkg::ROOT_QW - 2 - 2*j));
    always_ff @(posedge clk) begin
      sq_v_r[S_RQ+1+j] <= res.v;
      sq_r_r[S_RQ+1+j] <= res.r;
    end
  end

  // Low branch: linear term
  logic [63:0]                      ld_sum;
  logic [hcx_pkg::LIN_Y_W-1:0]      ld_y_r;
  logic [hcx_pkg::LIN_Y_W+25:0]     ld_p_r;
  logic [hcx_pkg::LIN_QW-1:0]       ld_q_r [S_LQ:S_RT];

  assign ld_sum = hcx_pkg::LIN_NUM * {32'd0, e_r[0]} + LIN_RND;

  always_ff @(posedge clk) begin
    ld_y_r <= ld_sum[ENERGY_FRAC_BITS +: hcx_pkg::LIN_Y_W];
    ld_p_r <= {26'd0, ld_y_r} * {{hcx_pkg::LIN_Y_W{1'b0}}, hcx_pkg::LIN_RECIP};
    ld_q_r[S_LQ] <= ld_p_r[hcx_pkg::LIN_RECIP_SH +: hcx_pkg::LIN_QW];
  end

  for (genvar s = S_LQ + 1; s <= S_RT; s++) begin : g_ldly
    always_ff @(posedge clk) begin
      ld_q_r[s] <= ld_q_r[s-1];
    end
  end

  // High branch: log2 by repeated squaring
  logic [4:0]  lz_n_r [1:S_HX];
  logic [4:0]  lz_nxt;
  logic [31:0] lg_x_r [2:S_HX-1];
  logic [29:0] lg_f_r [2:S_HX];

  always_comb begin
    lz_nxt = '0;
    for (int k = 0; k < 32; k++) begin
      if (e_r[0][k]) begin
        lz_nxt = 5'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    lz_n_r[1] <= lz_nxt;
    lz_n_r[2] <= lz_n_r[1];
    lg_x_r[2] <= e_r[1] << (5'd31 - lz_n_r[1]);
    lg_f_r[2] <= '0;
  end

  for (genvar i = 0; i < hcx_pkg::LOG_STEPS; i++) begin : g_log
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = {32'd0, lg_x_r[2+i]} * {32'd0, lg_x_r[2+i]};
    assign t = sq[63:31];
    always_ff @(posedge clk) begin
      if (i < hcx_pkg::LOG_STEPS - 1) begin
        lg_x_r[3+i] <= t[32] ? t[32:1] : t[31:0];
      end
      lg_f_r[3+i] <= {lg_f_r[2+i][28:0], t[32]};
      lz_n_r[3+i] <= lz_n_r[2+i];
    end
  end

  // High branch: natural log, scaling and rounded quotient
  logic [35:0] hl_l_r;
  logic [63:0] hl_ph_r;
  logic [63:0] hl_pl_r;
  logic [35:0] hl_ln_r;
  logic [63:0] hl_m_r;
  logic [63:0]                 hd_rem_r [S_HN:S_HQ-1];
  logic [hcx_pkg::HIGH_QW-1:0] hd_q_r   [S_HN:S_RT];

  always_ff @(posedge clk) begin
    hl_l_r <= ({31'd0, lz_n_r[S_HX]} << 30) + {6'd0, lg_f_r[S_HX]} - FRAC_OFS;
    hl_ph_r <= {46'd0, hl_l_r[35:18]} * hcx_pkg::LN2_Q28;
    hl_pl_r <= {46'd0, hl_l_r[17:0]} * hcx_pkg::LN2_Q28;
    hl_ln_r <= 36'(((hl_ph_r << 18) + hl_pl_r + (64'd1 << 27)) >> 28);
    hl_m_r <= {28'd0, hl_ln_r} * hcx_pkg::HIGH_SCALE;
    hd_rem_r[S_HN] <= hl_m_r + ({32'd0, e_r[S_HN-1]} << H_SH);
    hd_q_r[S_HN] <= '0;
  end

  for (genvar i = 0; i < hcx_pkg::HIGH_QW; i++) begin : g_hdiv
    hcx_pkg::div_res_t res;
    assign res = hcx_pkg::div_step(hd_rem_r[S_HN+i], {32'd0, e_r[S_HN+i]} << D_SH,
                                   hcx_pkg::HIGH_QW - 1 - i);
    always_ff @(posedge clk) begin
      if (i < hcx_pkg::HIGH_QW - 1) begin
        hd_rem_r[S_HN+1+i] <= res.rem;
      end
      hd_q_r[S_HN+1+i] <= {hd_q_r[S_HN+i][hcx_pkg::HIGH_QW-2:0], res.bit_q};
    end
  end

  for (genvar s = S_HQ + 1; s <= S_RT; s++) begin : g_hdly
    always_ff @(posedge clk) begin
      hd_q_r[s] <= hd_q_r[s-1];
    end
  end

  // Combine, select branch, saturate
  logic [63:0] xs_r;
  logic [21:0] xs_out_r;

  always_ff @(posedge clk) begin
    if (sel_r[S_RT]) begin
      xs_r <= hcx_pkg::LOW_CONST - {48'd0, ld_q_r[S_RT]}
              + {20'd0, (sq_r_r[S_RT] + 44'd1) >> 1};
    end else begin
      xs_r <= hcx_pkg::HIGH_CONST + {48'd0, hd_q_r[S_RT]};
    end
    xs_out_r <= (xs_r > {42'd0, hcx_pkg::XS_MAX}) ? hcx_pkg::XS_MAX : xs_r[21:0];
  end

  assign out_strobe = vld_r[LAT];
  assign out_cross_section = xs_out_r;

  a_lat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LAT+1) out_strobe)
    else $error("transaction result missing");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(vld_r[LAT-1]))
    else $error("valid chain broken");

  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S_RQ] && sel_r[S_RQ]) |-> (rd_q_r[S_RQ] != '0))
    else $error("low-branch quotient zero");

endmodule

>>> tb/tb_helium_charge_exchange_cross_section.sv
// Self-checking testbench for the helium charge-exchange cross-section evaluator.
`timescale 1ns / 100ps

module tb_helium_charge_exchange_cross_section;

  localparam int unsigned FRAC = 12;
  localparam int unsigned N_RANDOM = 1225;
  localparam longint unsigned E_FLOOR = ((64'd1 << FRAC) + 64'd50) / 64'd100;
  localparam longint unsigned E_KNEE = ((64'd3778 << FRAC) + 64'd5) / 64'd10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_energy = '0;
  logic        out_strobe;
  logic [21:0] out_cross_section;

  logic [21:0] xs_pending[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_seen = 0;
  int unsigned n_low = 0;

  typedef struct {
    logic [31:0] energy;
    logic        known;
    logic [21:0] xs;
  } energy_row_t;

  energy_row_t directed[$];

  helium_charge_exchange_cross_section #(.ENERGY_FRAC_BITS(FRAC)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_energy(in_energy),
    .out_strobe(out_strobe),
    .out_cross_section(out_cross_section)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_fix30(longint unsigned e);
    int unsigned n;
    longint unsigned m;
    longint unsigned f;
    n = 31;
    f = 0;
    while (n > 0 && e[n] == 1'b0) n--;
    m = e << (31 - n);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= (64'd1 << 32)) begin
        f = f | 64'd1;
        m = m >> 1;
      end
    end
    return (longint'(n) << 30) + f;
  endfunction

  function automatic logic [21:0] cross_section_of(logic [31:0] energy);
    longint unsigned e;
    longint unsigned scale;
    longint unsigned lin;
    longint unsigned rt;
    longint unsigned lg;
    longint unsigned ln;
    longint unsigned d;
    longint unsigned xs;
    e = energy;
    scale = 64'd1 << FRAC;
    if (e < E_FLOOR) e = E_FLOOR;
    if (e < E_KNEE) begin
      lin = (64'd78872 * e + 64'd500 * scale) / (64'd1000 * scale);
      rt = root_floor((64'd4 * 64'd198730 * 64'd198730 * scale) / e);
      xs = 64'd129960 - lin + ((rt + 64'd1) >> 1);
    end else begin
      lg = log2_fix30(e) - (longint'(FRAC) << 30);
      ln = (lg * 64'd186065279 + (64'd1 << 27)) >> 28;
      d = e << (30 - FRAC);
      xs = 64'd86407 + (ln * 64'd1555400 + d / 2) / d;
    end
    if (xs > 64'd4194303) xs = 64'd4194303;
    return xs[21:0];
  endfunction

  function automatic logic [31:0] random_energy();
    logic [31:0] e;
    case ($urandom_range(0, 5))
      0: e = $urandom();
      1: e = $urandom() >> $urandom_range(0, 31);
      2: e = $urandom_range(0, 32'(2 * E_FLOOR));
      3: e = 32'(E_KNEE - 64) + $urandom_range(0, 128);
      4: e = $urandom_range(0, 32'(E_KNEE));
      default: e = 32'(E_KNEE) + ($urandom() >> $urandom_range(4, 31));
    endcase
    return e;
  endfunction

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      xs_pending.push_back(cross_section_of(in_energy));
      n_sent++;
      if (in_energy < E_KNEE) n_low++;
    end
    if (rst_n && out_strobe) begin
      n_seen++;
      if (xs_pending.size() == 0) begin
        $error("unexpected transaction: cross_section %0d", out_cross_section);
        n_errors++;
      end else begin
        logic [21:0] want;
        want = xs_pending.pop_front();
        if (out_cross_section !== want) begin
          $error("cross_section: expected %0d, actual %0d", want, out_cross_section);
          n_errors++;
        end
      end
    end
  end

  task automatic send_energy(input logic [31:0] e);
    start <= 1'b1;
    in_energy <= e;
    forever begin
      @(negedge clk);
      if (!busy) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    in_energy <= $urandom();
    @(posedge clk);
  endtask

  initial begin
    #(12 * 400000);
    $display("[helium_charge_exchange_cross_section] ERROR");
    $finish;
  end

  initial begin
    logic [31:0] e;
    int unsigned spare;
    directed.push_back('{32'd0, 1'b0, '0});
    directed.push_back('{32'd1, 1'b0, '0});
    directed.push_back('{32'(E_FLOOR - 1), 1'b0, '0});
    directed.push_back('{32'(E_FLOOR), 1'b0, '0});
    directed.push_back('{32'(E_FLOOR + 1), 1'b0, '0});
    directed.push_back('{32'd4096, 1'b0, '0});
    directed.push_back('{32'(E_KNEE - 1), 1'b0, '0});
    directed.push_back('{32'(E_KNEE), 1'b0, '0});
    directed.push_back('{32'(E_KNEE + 1), 1'b0, '0});
    directed.push_back('{32'h0000_1000 << 10, 1'b0, '0});
    directed.push_back('{32'h5555_5555, 1'b0, '0});
    directed.push_back('{32'hAAAA_AAAA, 1'b0, '0});
    directed.push_back('{32'h8000_0000, 1'b0, '0});
    directed.push_back('{32'h7FFF_FFFF, 1'b0, '0});
    directed.push_back('{32'hFFFF_FFFF, 1'b0, '0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_energy(directed[i].energy);
      if (directed[i].known) begin
        if (cross_section_of(directed[i].energy) !== directed[i].xs) begin
          $error("cross_section: expected %0d, actual %0d", directed[i].xs,
                 cross_section_of(directed[i].energy));
          n_errors++;
        end
      end
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 700) begin
        start <= 1'b0;
        @(posedge clk);
        while (xs_pending.size() != 0) @(posedge clk);
      end
      if ((i < 400 || i > 650) && $urandom_range(0, 99) < 23) begin
        idle_cycle();
      end
      e = random_energy();
      send_energy(e);
    end
    start <= 1'b0;

    spare = 0;
    while (xs_pending.size() != 0 && spare < 2000) begin
      @(posedge clk);
      spare++;
    end
    repeat (80) @(posedge clk);

    $display("Sent %0d energies (%0d below the branch cutoff), checked %0d cross sections.",
             n_sent, n_low, n_seen);
    if (n_errors == 0 && xs_pending.size() == 0) begin
      $display("[helium_charge_exchange_cross_section] OK");
    end else begin
      if (xs_pending.size() != 0) $error("%0d transactions never arrived", xs_pending.size());
      $display("[helium_charge_exchange_cross_section] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/hcx_pkg.sv
rtl/helium_charge_exchange_cross_section.sv
tb/tb_helium_charge_exchange_cross_section.sv
